FILE: design/wfp_pkg.sv
package wfp_pkg;

    // Default depth of the per-target source tally.
    localparam int MAX_SOURCES_DEF = 32;

    // Stream payload widths.
    localparam int IN_DATA_W  = 160;
    localparam int OUT_DATA_W = 32;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_METRIC_MODE            = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NAN_WHEN_MANY_SOURCES  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NAN_WHEN_SHARED_SOURCE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_VALUE             = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_IS_NAN            = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_EXPLICIT_WEIGHT    = 3'd5;

    typedef enum logic [1:0] {
        MODE_SUM,
        MODE_MEAN,
        MODE_COUNT,
        MODE_ANGLE
    } metric_mode_t;

    typedef struct packed {
        metric_mode_t       metric_mode;
        logic               nan_when_many_sources;
        logic               nan_when_shared_source;
        logic signed [31:0] fill_value;
        logic               fill_is_nan;
        logic               use_explicit_weight;
    } cfg_t;

    // Iterative divider: 32 quotient bits, one per cycle.
    localparam int DIV_W     = 32;
    localparam int DIV_CNT_W = 5;

    // Saturation limits of the accumulators.
    localparam logic signed [55:0] WVS_MAX = {1'b0, {55{1'b1}}};
    localparam logic signed [55:0] WVS_MIN = {1'b1, {55{1'b0}}};
    localparam logic signed [39:0] DIR_MAX = {1'b0, {39{1'b1}}};
    localparam logic signed [39:0] DIR_MIN = {1'b1, {39{1'b0}}};

    // Angle constants in Q16.16.
    localparam int                 ANG_W       = 20;
    localparam logic signed [19:0] ANG_HALF_PI = 20'sd102944;
    localparam logic signed [19:0] ANG_PI      = 20'sd205887;
    localparam int                 CORDIC_STEPS = 16;

    // atan(2^-i) in Q16.16.
    function automatic logic signed [19:0] atan_entry(input logic [3:0] idx);
        logic signed [19:0] a;
        case (idx)
            4'd0:    a = 20'sd51472;
            4'd1:    a = 20'sd30386;
            4'd2:    a = 20'sd16055;
            4'd3:    a = 20'sd8150;
            4'd4:    a = 20'sd4091;
            4'd5:    a = 20'sd2047;
            4'd6:    a = 20'sd1024;
            4'd7:    a = 20'sd512;
            4'd8:    a = 20'sd256;
            4'd9:    a = 20'sd128;
            4'd10:   a = 20'sd64;
            4'd11:   a = 20'sd32;
            4'd12:   a = 20'sd16;
            4'd13:   a = 20'sd8;
            4'd14:   a = 20'sd4;
            4'd15:   a = 20'sd2;
            default: a = 20'sd0;
        endcase
        return a;
    endfunction

    // Datapath operations issued by the controller, one per cycle.
    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_EMPTY,
        OP_PROD,
        OP_ACC,
        OP_RES_NAN,
        OP_RES_SUM,
        OP_RES_COUNT,
        OP_MEAN_START,
        OP_RES_MEAN,
        OP_ANG_LOAD,
        OP_NORM,
        OP_SQ,
        OP_SUM,
        OP_ISQ_N,
        OP_CDIV,
        OP_CLAMP,
        OP_CSQ,
        OP_ISQ_Y,
        OP_CINIT,
        OP_CSTEP,
        OP_RES_ANG,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic         div_busy;
        logic         sqrt_busy;
        logic         last;
        logic         nan_now;
        metric_mode_t mode;
        logic         ws_zero;
        logic         mean_sat;
        logic         dir_zero;
        logic         norm_big;
        logic         cordic_last;
        logic         out_free;
    } dp_status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_WDIV,
        S_PROD,
        S_ACC,
        S_DECIDE,
        S_MEAN_DIV,
        S_NORM,
        S_SUM,
        S_ISQ_N,
        S_ISQ_N_WAIT,
        S_CDIV_WAIT,
        S_CSQ,
        S_ISQ_Y,
        S_ISQ_Y_WAIT,
        S_CORDIC,
        S_ANG_RES,
        S_EMIT
    } ctrl_state_t;

endpackage

FILE: design/wfp_div.sv
module wfp_div import wfp_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DIV_W-1:0] hi,
    input  logic [DIV_W-1:0] lo,
    input  logic [DIV_W-1:0] divisor,
    output logic             busy,
    output logic [DIV_W-1:0] quotient
);

    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIV_W-1:0]     dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic [DIV_W:0]       partial;

    // Restoring division: the high word must be below the divisor, so the
    // quotient fits one word. The low word shifts out as quotient bits shift in.
    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        partial   = {rem_reg, quo_reg[DIV_W-1]};
        if (start) begin
            rem_next  = hi;
            quo_next  = lo;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (partial >= {1'b0, dvs_reg}) begin
                rem_next = DIV_W'(partial - {1'b0, dvs_reg});
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = partial[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

FILE: design/wfp_isqrt.sv
module wfp_isqrt import wfp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        busy,
    output logic [31:0] root
);

    logic [63:0] v_reg, v_next;
    logic [63:0] r_reg, r_next;
    logic [63:0] bit_reg, bit_next;
    logic [63:0] trial;

    // Digit-by-digit square root, two radicand bits per cycle.
    always_comb begin
        v_next   = v_reg;
        r_next   = r_reg;
        bit_next = bit_reg;
        trial    = r_reg + bit_reg;
        if (start) begin
            v_next   = radicand;
            r_next   = '0;
            bit_next = 64'h4000_0000_0000_0000;
        end else if (bit_reg != '0) begin
            if (v_reg >= trial) begin
                v_next = v_reg - trial;
                r_next = (r_reg >> 1) + bit_reg;
            end else begin
                r_next = r_reg >> 1;
            end
            bit_next = bit_reg >> 2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_reg <= '0;
        end else begin
            bit_reg <= bit_next;
        end
    end

    always_ff @(posedge aclk) begin
        v_reg <= v_next;
        r_reg <= r_next;
    end

    assign busy = (bit_reg != '0);
    assign root = r_reg[31:0];

endmodule

FILE: design/wfp_datapath.sv
module wfp_datapath import wfp_pkg::*; #(
    parameter int MAX_SOURCES = MAX_SOURCES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dp_cmd_t               cmd,
    input  cfg_t                  cfg,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tlast,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser,
    output dp_status_t            status
);

    localparam int TALLY_W = $clog2(MAX_SOURCES + 1);

    // Input fields.
    logic signed [31:0] in_value;
    logic [23:0]        in_ew;
    logic [7:0]         in_share;
    logic [23:0]        in_e;

    assign in_value = s_tdata[31:0];
    assign in_ew    = s_tdata[55:32];
    assign in_share = s_tdata[63:56];
    assign in_e     = cfg.use_explicit_weight ? in_ew : 24'h01_0000;

    // Latched source element.
    logic signed [31:0] val_reg, val_next;
    logic [7:0]         share_reg, share_next;
    logic signed [15:0] sd_reg [3];
    logic signed [15:0] sd_next [3];
    logic signed [15:0] td_reg [3];
    logic signed [15:0] td_next [3];
    logic               last_reg, last_next;

    // Product stage.
    logic [23:0]        w_reg, w_next;
    logic signed [56:0] pv_reg, pv_next;
    logic signed [40:0] ps_reg [3];
    logic signed [40:0] ps_next [3];
    logic signed [31:0] dp_reg [3];
    logic signed [31:0] dp_next [3];

    // Accumulators.
    logic signed [55:0] wvs_reg, wvs_next;
    logic [31:0]        ws_reg, ws_next;
    logic [TALLY_W-1:0] tally_reg, tally_next;
    logic signed [39:0] dir_reg [3];
    logic signed [39:0] dir_next [3];
    logic               pend_reg, pend_next;

    // Angle working registers.
    logic [39:0]        mag_reg [3];
    logic [39:0]        mag_next [3];
    logic [2:0]         mneg_reg, mneg_next;
    logic [59:0]        sq_reg [3];
    logic [59:0]        sq_next [3];
    logic signed [46:0] tm_reg [3];
    logic signed [46:0] tm_next [3];
    logic [61:0]        n2_reg, n2_next;
    logic signed [48:0] dot_reg, dot_next;
    logic [30:0]        cmag_reg, cmag_next;
    logic               cneg_reg, cneg_next;
    logic [61:0]        csq_reg, csq_next;
    logic signed [33:0] x_reg, x_next;
    logic signed [33:0] y_reg, y_next;
    logic signed [ANG_W-1:0] z_reg, z_next;
    logic [3:0]         cnt_reg, cnt_next;

    // Result and output registers.
    logic signed [31:0] res_val_reg, res_val_next;
    logic               res_nan_reg, res_nan_next;
    logic               out_valid_reg, out_valid_next;
    logic [31:0]        out_val_reg, out_val_next;
    logic               out_nan_reg, out_nan_next;

    // Shared units.
    logic               div_start, div_busy;
    logic [DIV_W-1:0]   div_hi, div_lo, div_dvs, div_q;
    logic               sqrt_start, sqrt_busy;
    logic [63:0]        sqrt_in;
    logic [31:0]        sqrt_root;

    // Helper values.
    logic               wvs_neg;
    logic [55:0]        wvs_mag;
    logic               mean_sat;
    logic [47:0]        dot_mag;
    logic [63:0]        cdiv_num;
    logic signed [33:0] src_dot;
    logic signed [56:0] wvs_sum;
    logic [32:0]        ws_sum;
    logic signed [41:0] pdir [3];
    logic signed [41:0] pdir_sh [3];
    logic signed [40:0] dir_sum [3];
    logic signed [30:0] m_s [3];
    logic signed [33:0] x_sh, y_sh;

    assign wvs_neg  = wvs_reg[55];
    assign wvs_mag  = wvs_neg ? 56'(-wvs_reg) : 56'(wvs_reg);
    assign mean_sat = (wvs_mag >= {9'b0, ws_reg, 15'b0});
    assign dot_mag  = dot_reg[48] ? 48'(-dot_reg) : 48'(dot_reg);
    assign cdiv_num = {1'b0, dot_mag, 15'b0};

    // Divider and square root operand selection.
    always_comb begin
        div_start = 1'b0;
        div_hi    = '0;
        div_lo    = '0;
        div_dvs   = '0;
        case (cmd.op)
            OP_LOAD: begin
                div_start = 1'b1;
                div_lo    = 32'(in_e);
                div_dvs   = 32'(in_share);
            end
            OP_MEAN_START: begin
                div_start = 1'b1;
                div_hi    = wvs_mag[47:16];
                div_lo    = {wvs_mag[15:0], 16'b0};
                div_dvs   = ws_reg;
            end
            OP_CDIV: begin
                div_start = 1'b1;
                div_hi    = cdiv_num[63:32];
                div_lo    = cdiv_num[31:0];
                div_dvs   = sqrt_root;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        sqrt_start = 1'b0;
        sqrt_in    = '0;
        case (cmd.op)
            OP_ISQ_N: begin
                sqrt_start = 1'b1;
                sqrt_in    = 64'(n2_reg);
            end
            OP_ISQ_Y: begin
                sqrt_start = 1'b1;
                sqrt_in    = (64'(1) << 60) - 64'(csq_reg);
            end
            default: begin
            end
        endcase
    end

    wfp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .hi       (div_hi),
        .lo       (div_lo),
        .divisor  (div_dvs),
        .busy     (div_busy),
        .quotient (div_q)
    );

    wfp_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (sqrt_in),
        .busy     (sqrt_busy),
        .root     (sqrt_root)
    );

    // Accumulation terms for the current source.
    always_comb begin
        src_dot = 34'(dp_reg[0]) + 34'(dp_reg[1]) + 34'(dp_reg[2]);
        wvs_sum = 57'(wvs_reg) + (pv_reg >>> 16);
        ws_sum  = {1'b0, ws_reg} + 33'(w_reg);
        for (int i = 0; i < 3; i++) begin
            pdir[i]    = src_dot[33] ? -42'(ps_reg[i]) : 42'(ps_reg[i]);
            pdir_sh[i] = pdir[i] >>> 15;
            dir_sum[i] = 41'(dir_reg[i]) + 41'(pdir_sh[i]);
            m_s[i]     = mneg_reg[i] ? -$signed({1'b0, mag_reg[i][29:0]})
                                     : $signed({1'b0, mag_reg[i][29:0]});
        end
        x_sh = x_reg >>> cnt_reg;
        y_sh = y_reg >>> cnt_reg;
    end

    // Register updates by operation.
    always_comb begin
        val_next      = val_reg;
        share_next    = share_reg;
        last_next     = last_reg;
        w_next        = w_reg;
        pv_next       = pv_reg;
        wvs_next      = wvs_reg;
        ws_next       = ws_reg;
        tally_next    = tally_reg;
        pend_next     = pend_reg;
        mneg_next     = mneg_reg;
        n2_next       = n2_reg;
        dot_next      = dot_reg;
        cmag_next     = cmag_reg;
        cneg_next     = cneg_reg;
        csq_next      = csq_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        z_next        = z_reg;
        cnt_next      = cnt_reg;
        res_val_next  = res_val_reg;
        res_nan_next  = res_nan_reg;
        out_val_next  = out_val_reg;
        out_nan_next  = out_nan_reg;
        out_valid_next = out_valid_reg && !m_tready;
        for (int i = 0; i < 3; i++) begin
            sd_next[i]  = sd_reg[i];
            td_next[i]  = td_reg[i];
            ps_next[i]  = ps_reg[i];
            dp_next[i]  = dp_reg[i];
            dir_next[i] = dir_reg[i];
            mag_next[i] = mag_reg[i];
            sq_next[i]  = sq_reg[i];
            tm_next[i]  = tm_reg[i];
        end

        case (cmd.op)
            OP_LOAD: begin
                val_next   = in_value;
                share_next = in_share;
                last_next  = s_tlast;
                for (int i = 0; i < 3; i++) begin
                    sd_next[i] = s_tdata[64 + 16*i +: 16];
                    td_next[i] = s_tdata[112 + 16*i +: 16];
                end
            end
            OP_EMPTY: begin
                res_nan_next = cfg.fill_is_nan;
                res_val_next = cfg.fill_is_nan ? 32'sd0 : cfg.fill_value;
            end
            OP_PROD: begin
                w_next  = (share_reg == 8'd0) ? 24'd0 : div_q[23:0];
                pv_next = 57'(val_reg) * 57'($signed({1'b0, w_next}));
                for (int i = 0; i < 3; i++) begin
                    ps_next[i] = 41'(sd_reg[i]) * 41'($signed({1'b0, w_next}));
                    dp_next[i] = 32'(sd_reg[i]) * 32'(td_reg[i]);
                end
            end
            OP_ACC: begin
                if (wvs_sum > 57'(WVS_MAX)) begin
                    wvs_next = WVS_MAX;
                end else if (wvs_sum < 57'(WVS_MIN)) begin
                    wvs_next = WVS_MIN;
                end else begin
                    wvs_next = wvs_sum[55:0];
                end
                ws_next = ws_sum[32] ? 32'hFFFF_FFFF : ws_sum[31:0];
                if (tally_reg < TALLY_W'(MAX_SOURCES)) begin
                    tally_next = tally_reg + 1'b1;
                end
                if (share_reg != 8'd1 && cfg.nan_when_shared_source) begin
                    pend_next = 1'b1;
                end
                for (int i = 0; i < 3; i++) begin
                    if (dir_sum[i] > 41'(DIR_MAX)) begin
                        dir_next[i] = DIR_MAX;
                    end else if (dir_sum[i] < 41'(DIR_MIN)) begin
                        dir_next[i] = DIR_MIN;
                    end else begin
                        dir_next[i] = dir_sum[i][39:0];
                    end
                end
            end
            OP_RES_NAN: begin
                res_nan_next = 1'b1;
                res_val_next = '0;
            end
            OP_RES_SUM: begin
                res_nan_next = 1'b0;
                if (wvs_reg > 56'sh7FFF_FFFF) begin
                    res_val_next = 32'sh7FFF_FFFF;
                end else if (wvs_reg < -56'sh8000_0000) begin
                    res_val_next = 32'sh8000_0000;
                end else begin
                    res_val_next = wvs_reg[31:0];
                end
            end
            OP_RES_COUNT: begin
                res_nan_next = 1'b0;
                res_val_next = $signed(32'(tally_reg) << 16);
            end
            OP_RES_MEAN: begin
                res_nan_next = 1'b0;
                if (mean_sat) begin
                    res_val_next = wvs_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                end else begin
                    res_val_next = wvs_neg ? -$signed(div_q) : $signed(div_q);
                end
            end
            OP_ANG_LOAD: begin
                for (int i = 0; i < 3; i++) begin
                    mag_next[i]  = dir_reg[i][39] ? 40'(-dir_reg[i]) : 40'(dir_reg[i]);
                    mneg_next[i] = dir_reg[i][39];
                end
            end
            OP_NORM: begin
                for (int i = 0; i < 3; i++) begin
                    mag_next[i] = mag_reg[i] >> 1;
                end
            end
            OP_SQ: begin
                for (int i = 0; i < 3; i++) begin
                    sq_next[i] = 60'(mag_reg[i][29:0]) * 60'(mag_reg[i][29:0]);
                    tm_next[i] = 47'(td_reg[i]) * 47'(m_s[i]);
                end
            end
            OP_SUM: begin
                n2_next  = 62'(sq_reg[0]) + 62'(sq_reg[1]) + 62'(sq_reg[2]);
                dot_next = 49'(tm_reg[0]) + 49'(tm_reg[1]) + 49'(tm_reg[2]);
            end
            OP_CLAMP: begin
                cmag_next = (div_q > 32'h4000_0000) ? 31'h4000_0000 : div_q[30:0];
                cneg_next = dot_reg[48] && (div_q != '0);
            end
            OP_CSQ: begin
                csq_next = 62'(cmag_reg) * 62'(cmag_reg);
            end
            OP_CINIT: begin
                cnt_next = '0;
                if (cneg_reg) begin
                    x_next = 34'(sqrt_root);
                    y_next = 34'(cmag_reg);
                    z_next = ANG_HALF_PI;
                end else begin
                    x_next = 34'(cmag_reg);
                    y_next = 34'(sqrt_root);
                    z_next = '0;
                end
            end
            OP_CSTEP: begin
                if (y_reg > 34'sd0) begin
                    x_next = x_reg + y_sh;
                    y_next = y_reg - x_sh;
                    z_next = z_reg + atan_entry(cnt_reg);
                end else begin
                    x_next = x_reg - y_sh;
                    y_next = y_reg + x_sh;
                    z_next = z_reg - atan_entry(cnt_reg);
                end
                cnt_next = cnt_reg + 1'b1;
            end
            OP_RES_ANG: begin
                res_nan_next = 1'b0;
                if (z_reg < 0) begin
                    res_val_next = '0;
                end else if (z_reg > ANG_PI) begin
                    res_val_next = 32'(ANG_PI);
                end else begin
                    res_val_next = 32'(z_reg);
                end
            end
            OP_EMIT: begin
                out_valid_next = 1'b1;
                out_val_next   = res_val_reg;
                out_nan_next   = res_nan_reg;
            end
            default: begin
            end
        endcase

        // Each result or empty group starts the next target from zero.
        if (cmd.op == OP_EMIT || cmd.op == OP_EMPTY) begin
            wvs_next   = '0;
            ws_next    = '0;
            tally_next = '0;
            pend_next  = 1'b0;
            for (int i = 0; i < 3; i++) begin
                dir_next[i] = '0;
            end
        end
    end

    // Control state and accumulators.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            wvs_reg       <= '0;
            ws_reg        <= '0;
            tally_reg     <= '0;
            pend_reg      <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                dir_reg[i] <= '0;
            end
        end else begin
            out_valid_reg <= out_valid_next;
            wvs_reg       <= wvs_next;
            ws_reg        <= ws_next;
            tally_reg     <= tally_next;
            pend_reg      <= pend_next;
            for (int i = 0; i < 3; i++) begin
                dir_reg[i] <= dir_next[i];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        val_reg     <= val_next;
        share_reg   <= share_next;
        last_reg    <= last_next;
        w_reg       <= w_next;
        pv_reg      <= pv_next;
        mneg_reg    <= mneg_next;
        n2_reg      <= n2_next;
        dot_reg     <= dot_next;
        cmag_reg    <= cmag_next;
        cneg_reg    <= cneg_next;
        csq_reg     <= csq_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        z_reg       <= z_next;
        cnt_reg     <= cnt_next;
        res_val_reg <= res_val_next;
        res_nan_reg <= res_nan_next;
        out_val_reg <= out_val_next;
        out_nan_reg <= out_nan_next;
        for (int i = 0; i < 3; i++) begin
            sd_reg[i]  <= sd_next[i];
            td_reg[i]  <= td_next[i];
            ps_reg[i]  <= ps_next[i];
            dp_reg[i]  <= dp_next[i];
            mag_reg[i] <= mag_next[i];
            sq_reg[i]  <= sq_next[i];
            tm_reg[i]  <= tm_next[i];
        end
    end

    // Status for the controller.
    always_comb begin
        status.div_busy    = div_busy;
        status.sqrt_busy   = sqrt_busy;
        status.last        = last_reg;
        status.nan_now     = pend_reg ||
                             (tally_reg > TALLY_W'(1) && cfg.nan_when_many_sources);
        status.mode        = cfg.metric_mode;
        status.ws_zero     = (ws_reg == '0);
        status.mean_sat    = mean_sat;
        status.dir_zero    = (dir_reg[0] == '0) && (dir_reg[1] == '0) && (dir_reg[2] == '0);
        status.norm_big    = (mag_reg[0][39:30] != '0) || (mag_reg[1][39:30] != '0) ||
                             (mag_reg[2][39:30] != '0);
        status.cordic_last = (cnt_reg == 4'(CORDIC_STEPS - 1));
        status.out_free    = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_val_reg;
    assign m_tuser  = out_nan_reg;

endmodule

FILE: design/wfp_ctrl.sv
module wfp_ctrl import wfp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tuser,
    input  dp_status_t status,
    output logic       s_tready,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath operation.
    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NOP;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser) begin
                        cmd.op     = OP_EMPTY;
                        state_next = S_EMIT;
                    end else begin
                        cmd.op     = OP_LOAD;
                        state_next = S_WDIV;
                    end
                end
            end
            S_WDIV: begin
                if (!status.div_busy) begin
                    state_next = S_PROD;
                end
            end
            S_PROD: begin
                cmd.op     = OP_PROD;
                state_next = S_ACC;
            end
            S_ACC: begin
                cmd.op     = OP_ACC;
                state_next = status.last ? S_DECIDE : S_IDLE;
            end
            S_DECIDE: begin
                state_next = S_EMIT;
                if (status.nan_now) begin
                    cmd.op = OP_RES_NAN;
                end else begin
                    case (status.mode)
                        MODE_SUM:   cmd.op = OP_RES_SUM;
                        MODE_COUNT: cmd.op = OP_RES_COUNT;
                        MODE_MEAN: begin
                            if (status.ws_zero) begin
                                cmd.op = OP_RES_NAN;
                            end else if (status.mean_sat) begin
                                cmd.op = OP_RES_MEAN;
                            end else begin
                                cmd.op     = OP_MEAN_START;
                                state_next = S_MEAN_DIV;
                            end
                        end
                        MODE_ANGLE: begin
                            if (status.dir_zero) begin
                                cmd.op = OP_RES_NAN;
                            end else begin
                                cmd.op     = OP_ANG_LOAD;
                                state_next = S_NORM;
                            end
                        end
                        default: cmd.op = OP_RES_NAN;
                    endcase
                end
            end
            S_MEAN_DIV: begin
                if (!status.div_busy) begin
                    cmd.op     = OP_RES_MEAN;
                    state_next = S_EMIT;
                end
            end
            S_NORM: begin
                if (status.norm_big) begin
                    cmd.op = OP_NORM;
                end else begin
                    cmd.op     = OP_SQ;
                    state_next = S_SUM;
                end
            end
            S_SUM: begin
                cmd.op     = OP_SUM;
                state_next = S_ISQ_N;
            end
            S_ISQ_N: begin
                cmd.op     = OP_ISQ_N;
                state_next = S_ISQ_N_WAIT;
            end
            S_ISQ_N_WAIT: begin
                if (!status.sqrt_busy) begin
                    cmd.op     = OP_CDIV;
                    state_next = S_CDIV_WAIT;
                end
            end
            S_CDIV_WAIT: begin
                if (!status.div_busy) begin
                    cmd.op     = OP_CLAMP;
                    state_next = S_CSQ;
                end
            end
            S_CSQ: begin
                cmd.op     = OP_CSQ;
                state_next = S_ISQ_Y;
            end
            S_ISQ_Y: begin
                cmd.op     = OP_ISQ_Y;
                state_next = S_ISQ_Y_WAIT;
            end
            S_ISQ_Y_WAIT: begin
                if (!status.sqrt_busy) begin
                    cmd.op     = OP_CINIT;
                    state_next = S_CORDIC;
                end
            end
            S_CORDIC: begin
                cmd.op = OP_CSTEP;
                if (status.cordic_last) begin
                    state_next = S_ANG_RES;
                end
            end
            S_ANG_RES: begin
                cmd.op     = OP_RES_ANG;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (status.out_free) begin
                    cmd.op     = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: design/weighted_fixel_projection_unit.sv
// Each source transaction waits on the one-bit-per-cycle divider that forms the weight.
// A closing source then forms its result: directly for sum, count or nan results, with
// the same divider for the mean, and for the angle with up to 10 normalize shifts, two
// square roots, one divide and 16 CORDIC steps. An empty group goes straight to emit.
// One target is worked on at a time; a finished result waits in the output register.
// Reset is synchronous, active low; it clears state, config, output valid and accumulators.
module weighted_fixel_projection_unit import wfp_pkg::*; #(
    parameter int MAX_SOURCES = MAX_SOURCES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Source transactions.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // From bit 0: source_value, explicit_weight, share_count, source_dir_x,
    // source_dir_y, source_dir_z, target_dir_x, target_dir_y, target_dir_z.
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tlast,
    // Bit 0: empty_group.
    input  logic                  s_tuser,
    // Result transactions.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // Bit 0 up: result_value.
    output logic [OUT_DATA_W-1:0] m_tdata,
    // Bit 0: result_nan.
    output logic                  m_tuser,
    // Configuration writes.
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t       cfg_reg, cfg_next;
    dp_cmd_t    cmd;
    dp_status_t status;

    // Configuration registers.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_addr)
                CFG_METRIC_MODE:            cfg_next.metric_mode = metric_mode_t'(cfg_wdata[1:0]);
                CFG_NAN_WHEN_MANY_SOURCES:  cfg_next.nan_when_many_sources = cfg_wdata[0];
                CFG_NAN_WHEN_SHARED_SOURCE: cfg_next.nan_when_shared_source = cfg_wdata[0];
                CFG_FILL_VALUE:             cfg_next.fill_value = cfg_wdata;
                CFG_FILL_IS_NAN:            cfg_next.fill_is_nan = cfg_wdata[0];
                CFG_USE_EXPLICIT_WEIGHT:    cfg_next.use_explicit_weight = cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.metric_mode            <= MODE_SUM;
            cfg_reg.nan_when_many_sources  <= 1'b0;
            cfg_reg.nan_when_shared_source <= 1'b0;
            cfg_reg.fill_value             <= '0;
            cfg_reg.fill_is_nan            <= 1'b1;
            cfg_reg.use_explicit_weight    <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Sequencer.
    wfp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .status   (status),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    // Arithmetic and output register.
    wfp_datapath #(
        .MAX_SOURCES (MAX_SOURCES)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .cfg      (cfg_reg),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .status   (status)
    );

    // A nan result always carries a zero value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("nan result with nonzero value");

    // A new source is only taken when neither iterative unit is running.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !status.div_busy && !status.sqrt_busy)
        else $error("source accepted while a shared unit is busy");

    // A result appears only after the sequencer issued an emit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd.op == OP_EMIT))
        else $error("result valid without emit");

endmodule

FILE: tb/sv/tb_weighted_fixel_projection_unit.sv
module tb_weighted_fixel_projection_unit;
    import wfp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  TALLY_LIMIT = 32;
    localparam int  NUM_PHASES  = 8;
    localparam int  PHASE_ITEMS = 190;
    localparam longint ACC_MAX  = 64'sd36028797018963967;
    localparam longint DSUM_MAX = 64'sd549755813887;
    localparam longint HALF_PI  = 64'sd102944;
    localparam longint FULL_PI  = 64'sd205887;

    typedef struct {
        bit                 empty;
        bit                 last;
        logic signed [31:0] value;
        logic [23:0]        eweight;
        logic [7:0]         share;
        logic signed [15:0] sdir [3];
        logic signed [15:0] tdir [3];
    } src_item_t;

    typedef struct {
        logic [31:0] value;
        bit          nan;
    } target_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Mirror of the configuration registers.
    metric_mode_t cur_mode = MODE_SUM;
    bit           cur_nan_many = 1'b0;
    bit           cur_nan_shared = 1'b0;
    logic [31:0]  cur_fill = '0;
    bit           cur_fill_nan = 1'b1;
    bit           cur_use_ew = 1'b0;

    // Mirror of the per-target accumulators.
    longint       acc_value = 0;
    longint       acc_weight = 0;
    int           acc_tally = 0;
    longint       acc_dir [3] = '{0, 0, 0};
    bit           acc_nan = 1'b0;

    src_item_t      pending_sources [$];
    target_result_t expected_results [$];
    int             mismatches = 0;
    int             results_seen = 0;
    int             sources_sent = 0;
    int             nan_results = 0;
    bit             idle_en = 1'b1;

    weighted_fixel_projection_unit dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint clip(input longint v, input longint hi);
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic void clear_target();
        acc_value = 0;
        acc_weight = 0;
        acc_tally = 0;
        acc_dir = '{0, 0, 0};
        acc_nan = 1'b0;
    endfunction

    // Appends one item to the stimulus queue.
    function automatic void enqueue_source(input src_item_t it);
        pending_sources.insert(pending_sources.size(), it);
    endfunction

    // Weighted mean with truncation toward zero; returns 0 when the weight sum is zero.
    function automatic bit mean_of_target(output longint res);
        longint unsigned mag, q, r, v;
        bit neg;
        neg = acc_value < 0;
        res = 0;
        if (acc_weight == 0) return 1'b0;
        mag = neg ? longint'(-acc_value) : acc_value;
        q = mag / acc_weight;
        r = mag % acc_weight;
        if (q >= 32768) v = 64'd1 << 31;
        else v = q * 65536 + (r * 65536) / acc_weight;
        if (neg) res = -longint'(v);
        else res = (v > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : longint'(v);
        return 1'b1;
    endfunction

    function automatic longint atan_of_step(input int i);
        longint steps [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                               256, 128, 64, 32, 16, 8, 4, 2};
        return steps[i];
    endfunction

    // Angle between the target direction and the aligned direction sum, by CORDIC.
    function automatic bit angle_of_target(input longint tdir [3], output longint res);
        longint m [3];
        longint dot, c, x, y, z, nx, ny, n2, tmp;
        longint unsigned mags [3];
        longint unsigned maxm, n;
        int k;
        dot = 0; n2 = 0; z = 0; maxm = 0; k = 0;
        res = 0;
        for (int i = 0; i < 3; i++) begin
            mags[i] = acc_dir[i] < 0 ? longint'(-acc_dir[i]) : acc_dir[i];
            if (mags[i] > maxm) maxm = mags[i];
        end
        if (maxm == 0) return 1'b0;
        while ((maxm >> k) >= (64'd1 << 30)) k++;
        for (int i = 0; i < 3; i++) begin
            m[i] = longint'(mags[i] >> k);
            if (acc_dir[i] < 0) m[i] = -m[i];
            n2 += m[i] * m[i];
            dot += tdir[i] * m[i];
        end
        n = int_sqrt(n2);
        c = (dot * 32768) / longint'(n);
        if (c > (64'sd1 << 30)) c = 64'sd1 << 30;
        if (c < -(64'sd1 << 30)) c = -(64'sd1 << 30);
        x = c;
        y = longint'(int_sqrt((64'd1 << 60) - c * c));
        if (x < 0) begin
            tmp = x;
            x = y;
            y = -tmp;
            z = HALF_PI;
        end
        for (int i = 0; i < 16; i++) begin
            if (y > 0) begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z += atan_of_step(i);
            end else begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z -= atan_of_step(i);
            end
            x = nx;
            y = ny;
        end
        if (z < 0) z = 0;
        if (z > FULL_PI) z = FULL_PI;
        res = z;
        return 1'b1;
    endfunction

    // Folds one accepted source into the target and queues the result it closes.
    function automatic void project_source(input src_item_t it);
        longint w, e, dot, p, res;
        longint sd [3], td [3];
        bit nan;
        target_result_t r;
        dot = 0;
        res = 0;
        if (it.empty) begin
            clear_target();
            r.value = cur_fill_nan ? 32'd0 : cur_fill;
            r.nan = cur_fill_nan;
            expected_results.insert(expected_results.size(), r);
            return;
        end
        e = cur_use_ew ? longint'(it.eweight) : 65536;
        w = (it.share != 0) ? e / longint'(it.share) : 0;
        for (int i = 0; i < 3; i++) begin
            sd[i] = it.sdir[i];
            td[i] = it.tdir[i];
            dot += sd[i] * td[i];
        end
        acc_value = clip(acc_value + ((longint'(it.value) * w) >>> 16), ACC_MAX);
        acc_weight += w;
        if (acc_weight > 64'sh FFFF_FFFF) acc_weight = 64'sh FFFF_FFFF;
        if (acc_tally < TALLY_LIMIT) acc_tally++;
        if (it.share != 1 && cur_nan_shared) acc_nan = 1'b1;
        for (int i = 0; i < 3; i++) begin
            p = sd[i] * w;
            if (dot < 0) p = -p;
            acc_dir[i] = clip(acc_dir[i] + (p >>> 15), DSUM_MAX);
        end
        if (!it.last) return;
        nan = acc_nan || (acc_tally > 1 && cur_nan_many);
        if (!nan) begin
            case (cur_mode)
                MODE_SUM:   res = clip(acc_value, 64'sh7FFF_FFFF);
                MODE_MEAN:  nan = !mean_of_target(res);
                MODE_COUNT: res = longint'(acc_tally) * 65536;
                default:    nan = !angle_of_target(td, res);
            endcase
        end
        if (nan) res = 0;
        r.value = res[31:0];
        r.nan = nan;
        expected_results.insert(expected_results.size(), r);
        clear_target();
    endfunction

    function automatic int gap_len();
        if (!idle_en || $urandom_range(0, 2) != 0) return 0;
        return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
    endfunction

    // Source driver: presents the oldest pending item and predicts it on acceptance.
    int src_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                project_source(pending_sources.pop_front());
                sources_sent++;
                src_gap = gap_len();
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_sources.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tlast <= pending_sources[0].last;
                    s_tuser <= pending_sources[0].empty;
                    s_tdata <= {pending_sources[0].tdir[2], pending_sources[0].tdir[1],
                                pending_sources[0].tdir[0], pending_sources[0].sdir[2],
                                pending_sources[0].sdir[1], pending_sources[0].sdir[0],
                                pending_sources[0].share, pending_sources[0].eweight,
                                pending_sources[0].value};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // One long receiver hold-off, counted in cycles, started while items are waiting.
    int  cycle_cnt = 0;
    int  hold_cnt = 0;
    bit  hold_used = 1'b0;
    always @(posedge aclk) begin
        if (aresetn) begin
            cycle_cnt <= cycle_cnt + 1;
            if (!hold_used && cycle_cnt >= 20000 && pending_sources.size() > 20) begin
                hold_used <= 1'b1;
                hold_cnt <= 400;
            end else if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
            end
        end
    end

    // Result monitor with random back-pressure.
    int  stall_cnt = 0;
    always @(posedge aclk) begin
        target_result_t exp_r;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (m_tuser) nan_results++;
                if (expected_results.size() == 0) begin
                    flag_mismatch("unexpected result", m_tdata, 32'd0);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (m_tdata !== exp_r.value)
                        flag_mismatch("result_value", m_tdata, exp_r.value);
                    if (m_tuser !== exp_r.nan)
                        flag_mismatch("result_nan", {31'd0, m_tuser}, {31'd0, exp_r.nan});
                end
            end
            if (hold_cnt > 0) begin
                m_tready <= 1'b0;
            end else if (stall_cnt > 0) begin
                stall_cnt--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                stall_cnt = gap_len();
            end
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_sources.size() > 0 || expected_results.size() > 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'd0;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic src_item_t rand_source(input bit last);
        src_item_t it;
        logic [31:0] wd;
        it.empty = 1'b0;
        it.last = last;
        it.value = pick_word();
        wd = pick_word();
        it.eweight = ($urandom_range(0, 3) == 0) ? wd[23:0] : 24'($urandom_range(0, 131072));
        it.share = ($urandom_range(0, 9) < 7) ? 8'd1 : 8'($urandom_range(0, 255));
        for (int i = 0; i < 3; i++) begin
            wd = pick_word();
            it.sdir[i] = ($urandom_range(0, 15) == 0) ? 16'sd0 : wd[15:0];
            wd = pick_word();
            it.tdir[i] = wd[15:0];
        end
        return it;
    endfunction

    function automatic src_item_t empty_item();
        src_item_t it = rand_source(1'b0);
        it.empty = 1'b1;
        it.last = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // Random targets: mostly well-formed groups, some empty, some noise.
    task automatic push_random(input int count);
        src_item_t it;
        int added = 0;
        int len;
        while (added < count) begin
            case ($urandom_range(0, 19))
                0: begin
                    enqueue_source(empty_item());
                    added++;
                end
                1: begin
                    it = rand_source(1'($urandom_range(0, 1)));
                    enqueue_source(it);
                    if ($urandom_range(0, 1)) enqueue_source(empty_item());
                    added += 2;
                end
                default: begin
                    len = ($urandom_range(0, 29) == 0) ? $urandom_range(30, 40)
                                                       : $urandom_range(1, 4);
                    for (int i = 0; i < len; i++)
                        enqueue_source(rand_source(i == len - 1));
                    added += len;
                end
            endcase
        end
        enqueue_source(rand_source(1'b1));
    endtask

    // Directed edge cases: extremes, zero weights, opposite and orthogonal directions.
    task automatic push_directed();
        src_item_t it;
        enqueue_source(empty_item());
        it = rand_source(1'b1);
        it.value = 32'h7FFF_FFFF; it.eweight = 24'hFF_FFFF; it.share = 8'd1;
        enqueue_source(it);
        it.value = 32'h8000_0000;
        enqueue_source(it);
        it.share = 8'd0;
        enqueue_source(it);
        it.share = 8'd255; it.eweight = 24'd0;
        enqueue_source(it);
        it = rand_source(1'b1);
        it.share = 8'd1; it.eweight = 24'h01_0000;
        it.sdir = '{16'sh7FFF, 16'sh0000, 16'sh0000};
        it.tdir = '{16'sh8000, 16'sh0000, 16'sh0000};
        enqueue_source(it);
        it.tdir = '{16'sh7FFF, 16'sh0000, 16'sh0000};
        enqueue_source(it);
        it.tdir = '{16'sh0000, 16'sh7FFF, 16'sh0000};
        enqueue_source(it);
        it.sdir = '{16'sh8000, 16'sh8000, 16'sh8000};
        it.tdir = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
        enqueue_source(it);
        it.sdir = '{16'sh0000, 16'sh0000, 16'sh0000};
        enqueue_source(it);
        it = rand_source(1'b0);
        it.share = 8'd1;
        enqueue_source(it);
        enqueue_source(empty_item());
        it.share = 8'd2;
        enqueue_source(it);
        it.last = 1'b1;
        enqueue_source(it);
    endtask

    // Stimulus: reset, then phases of configuration and traffic.
    initial begin
        logic [31:0] fills [3];
        fills = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0};
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_idle();
            cur_mode = metric_mode_t'(ph % 4);
            cur_nan_many = (ph > 1) && $urandom_range(0, 2) == 0;
            cur_nan_shared = (ph > 1) && $urandom_range(0, 2) == 0;
            cur_fill = (ph < 3) ? fills[ph] : $urandom;
            cur_fill_nan = (ph == 0) || $urandom_range(0, 3) == 0;
            cur_use_ew = (ph % 2 == 0) ? 1'b1 : 1'($urandom_range(0, 1));
            idle_en = (ph != 5);
            cfg_write(CFG_METRIC_MODE, {30'd0, cur_mode});
            cfg_write(CFG_NAN_WHEN_MANY_SOURCES, {31'd0, cur_nan_many});
            cfg_write(CFG_NAN_WHEN_SHARED_SOURCE, {31'd0, cur_nan_shared});
            cfg_write(CFG_FILL_VALUE, cur_fill);
            cfg_write(CFG_FILL_IS_NAN, {31'd0, cur_fill_nan});
            cfg_write(CFG_USE_EXPLICIT_WEIGHT, {31'd0, cur_use_ew});
            if (ph < 4) push_directed();
            push_random(PHASE_ITEMS);
        end
        wait_idle();
        $display("Sent %0d source transactions over %0d settings; checked %0d results",
                 sources_sent, NUM_PHASES, results_seen);
        $display("(%0d flagged nan), in all four metric modes.", nan_results);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end

endmodule
